>>> sv/lfu_cache_table_assert.svh
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shorthand for the clocked, reset-qualified checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache table package
// Command codes, update modes and control bundles shared by the modules.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        UPD_NONE   = 2'd0,
        UPD_TOUCH  = 2'd1,
        UPD_EVICT  = 2'd2,
        UPD_INSERT = 2'd3
    } upd_mode_t;

    typedef struct packed {
        logic start;
        logic check;
    } scan_ctrl_t;

    typedef struct packed {
        logic tag_we;
        logic value_we;
        logic count_we;
        logic rank_we;
    } slot_wr_t;

endpackage
`default_nettype wire

>>> sv/lfu_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFU slot memory
// Tag, value, use count and recency rank stores with registered reads.
// ----------------------------------------------------------------------------
module lfu_slot_mem
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int TAG_BITS    = 32,
    parameter int COUNT_BITS  = 16,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
)
(
    input  wire logic                  clk,
    input  wire logic [IW-1:0]         rd_addr,
    input  wire slot_wr_t              wr,
    input  wire logic [IW-1:0]         entry_waddr,
    input  wire logic [TAG_BITS-1:0]   wr_tag,
    input  wire logic [VALUE_BITS-1:0] wr_value,
    input  wire logic [COUNT_BITS-1:0] wr_count,
    input  wire logic [IW-1:0]         rank_waddr,
    input  wire logic [IW-1:0]         wr_rank,
    output logic      [TAG_BITS-1:0]   rd_tag,
    output logic      [VALUE_BITS-1:0] rd_value,
    output logic      [COUNT_BITS-1:0] rd_count,
    output logic      [IW-1:0]         rd_rank
);

    logic [TAG_BITS-1:0]   tag_mem   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [MAX_ENTRIES];
    logic [IW-1:0]         rank_mem  [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.tag_we)
        begin
            tag_mem[entry_waddr] <= wr_tag;
        end
        if (wr.value_we)
        begin
            value_mem[entry_waddr] <= wr_value;
        end
        if (wr.count_we)
        begin
            count_mem[entry_waddr] <= wr_count;
        end
        if (wr.rank_we)
        begin
            rank_mem[rank_waddr] <= wr_rank;
        end
        rd_tag   <= tag_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
        rd_count <= count_mem[rd_addr];
        rd_rank  <= rank_mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> sv/lfu_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFU scan unit
// Examines one slot per cycle and keeps the match, first free slot and victim.
// ----------------------------------------------------------------------------
module lfu_scan
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int TAG_BITS    = 32,
    parameter int COUNT_BITS  = 16,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scan_ctrl_t            ctrl,
    input  wire logic [IW-1:0]         pos,
    input  wire logic                  entry_valid,
    input  wire logic [TAG_BITS-1:0]   key,
    input  wire logic [TAG_BITS-1:0]   rd_tag,
    input  wire logic [VALUE_BITS-1:0] rd_value,
    input  wire logic [COUNT_BITS-1:0] rd_count,
    input  wire logic [IW-1:0]         rd_rank,
    output logic                       match_found,
    output logic      [IW-1:0]         match_idx,
    output logic      [VALUE_BITS-1:0] match_value,
    output logic      [COUNT_BITS-1:0] match_count,
    output logic      [IW-1:0]         match_rank,
    output logic                       free_found,
    output logic      [IW-1:0]         free_idx,
    output logic                       victim_found,
    output logic      [IW-1:0]         victim_idx,
    output logic      [TAG_BITS-1:0]   victim_tag,
    output logic      [IW-1:0]         victim_rank
);

    logic                  match_found_reg, match_found_next;
    logic                  free_found_reg, free_found_next;
    logic                  victim_found_reg, victim_found_next;
    logic [IW-1:0]         match_idx_reg;
    logic [VALUE_BITS-1:0] match_value_reg;
    logic [COUNT_BITS-1:0] match_count_reg;
    logic [IW-1:0]         match_rank_reg;
    logic [IW-1:0]         free_idx_reg;
    logic [IW-1:0]         victim_idx_reg;
    logic [TAG_BITS-1:0]   victim_tag_reg;
    logic [COUNT_BITS-1:0] victim_count_reg;
    logic [IW-1:0]         victim_rank_reg;
    logic                  take_match;
    logic                  take_free;
    logic                  take_victim;

    assign take_match  = ctrl.check && entry_valid && (rd_tag == key) && !match_found_reg;
    assign take_free   = ctrl.check && !entry_valid && !free_found_reg;
    assign take_victim = ctrl.check && entry_valid &&
                         (!victim_found_reg || (rd_count < victim_count_reg) ||
                          ((rd_count == victim_count_reg) && (rd_rank > victim_rank_reg)));

    always_comb
    begin
        match_found_next  = match_found_reg;
        free_found_next   = free_found_reg;
        victim_found_next = victim_found_reg;
        if (ctrl.start)
        begin
            match_found_next  = 1'b0;
            free_found_next   = 1'b0;
            victim_found_next = 1'b0;
        end
        else
        begin
            if (take_match)
            begin
                match_found_next = 1'b1;
            end
            if (take_free)
            begin
                free_found_next = 1'b1;
            end
            if (take_victim)
            begin
                victim_found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg  <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
        end
        else
        begin
            match_found_reg  <= match_found_next;
            free_found_reg   <= free_found_next;
            victim_found_reg <= victim_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            match_idx_reg   <= pos;
            match_value_reg <= rd_value;
            match_count_reg <= rd_count;
            match_rank_reg  <= rd_rank;
        end
        if (take_free)
        begin
            free_idx_reg <= pos;
        end
        if (take_victim)
        begin
            victim_idx_reg   <= pos;
            victim_tag_reg   <= rd_tag;
            victim_count_reg <= rd_count;
            victim_rank_reg  <= rd_rank;
        end
    end

    assign match_found  = match_found_reg;
    assign match_idx    = match_idx_reg;
    assign match_value  = match_value_reg;
    assign match_count  = match_count_reg;
    assign match_rank   = match_rank_reg;
    assign free_found   = free_found_reg;
    assign free_idx     = free_idx_reg;
    assign victim_found = victim_found_reg;
    assign victim_idx   = victim_idx_reg;
    assign victim_tag   = victim_tag_reg;
    assign victim_rank  = victim_rank_reg;

endmodule
`default_nettype wire

>>> sv/lfu_cache_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache table
// Fully associative least-frequently-used cache of tags with one value each.
// ----------------------------------------------------------------------------
// An item enters on the input channel (in_valid, in_stall) with cmd, key_tag
// and put_value, and exactly one result item leaves on the output channel
// (out_valid, out_stall) with hit, read_value, evicted, evicted_tag and
// ignored. The capacity register is written over cfg_valid/cfg_ready with
// capacity_in_use as data; cfg_ready is always high.
// Each item first walks all MAX_ENTRIES slots through one registered memory
// read port to find the match, the first free slot and the victim. A get
// miss or an ignored put then finishes; any other item walks the slots a
// second time to rewrite the recency ranks. One item is worked on at a
// time; in_stall is low only between items, so a new item is taken only
// after the last one has left its final step.
// The result sits in an output register; a stall holds it, and a finished
// item waits in its last step until the register is free. Reset empties
// the table and sets the capacity to 10.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_assert.svh"

module lfu_cache_table
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int TAG_BITS    = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CAP_BITS-1:0]   capacity_in_use,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  cmd,
    input  wire logic [KEY_BITS-1:0]   key_tag,
    input  wire logic [VALUE_BITS-1:0] put_value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       hit,
    output logic      [VALUE_BITS-1:0] read_value,
    output logic                       evicted,
    output logic      [KEY_BITS-1:0]   evicted_tag,
    output logic                       ignored
);

    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CAPW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(10);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CAP_BITS-1:0]     cap_reg;
    logic [MAX_ENTRIES-1:0]  valid_reg, valid_next;
    logic [CW-1:0]           occ_reg, occ_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [IW-1:0]           pos_reg;
    logic                    chk_reg, chk_next;
    upd_mode_t               mode_reg, mode_next;
    logic [IW-1:0]           target_reg, target_next;
    logic                    ign_reg, ign_next;
    logic                    cmd_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg;
    logic [VALUE_BITS-1:0]   read_value_reg;
    logic                    evicted_reg;
    logic [KEY_BITS-1:0]     evicted_tag_reg;
    logic                    ignored_reg;

    logic                    in_accept;
    logic                    fin_go;
    logic                    walking;
    logic                    walk_done;
    logic [CAPW-1:0]         cap_eff;
    logic [TAG_BITS-1:0]     key_masked;
    logic [KEY_BITS-1:0]     victim_tag_out;
    scan_ctrl_t              scan_ctrl;
    slot_wr_t                slot_wr;
    logic [IW-1:0]           rank_new;
    logic [COUNT_BITS-1:0]   count_new;

    logic [TAG_BITS-1:0]     rd_tag;
    logic [VALUE_BITS-1:0]   rd_value;
    logic [COUNT_BITS-1:0]   rd_count;
    logic [IW-1:0]           rd_rank;
    logic                    match_found;
    logic [IW-1:0]           match_idx;
    logic [VALUE_BITS-1:0]   match_value;
    logic [COUNT_BITS-1:0]   match_count;
    logic [IW-1:0]           match_rank;
    logic                    free_found;
    logic [IW-1:0]           free_idx;
    logic                    victim_found;
    logic [IW-1:0]           victim_idx;
    logic [TAG_BITS-1:0]     victim_tag;
    logic [IW-1:0]           victim_rank;

    genvar g;
    generate
        for (g = 0; g < TAG_BITS; g++)
        begin : gen_key
            if (g < KEY_BITS)
            begin : gen_bit
                assign key_masked[g] = key_reg[g];
            end
            else
            begin : gen_zero
                assign key_masked[g] = 1'b0;
            end
        end
        for (g = 0; g < KEY_BITS; g++)
        begin : gen_evtag
            if (g < TAG_BITS)
            begin : gen_bit
                assign victim_tag_out[g] = victim_tag[g];
            end
            else
            begin : gen_zero
                assign victim_tag_out[g] = 1'b0;
            end
        end
    endgenerate

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign fin_go    = !out_valid_reg || !out_stall;
    assign walking   = (state_reg == ST_SCAN) || (state_reg == ST_UPDATE);
    assign walk_done = (cnt_reg == CW'(MAX_ENTRIES));

    assign cap_eff = (CAPW'(cap_reg) > CAPW'(MAX_ENTRIES)) ? CAPW'(MAX_ENTRIES)
                                                          : CAPW'(cap_reg);

    assign scan_ctrl.start = in_accept;
    assign scan_ctrl.check = (state_reg == ST_SCAN) && chk_reg;

    assign count_new = (match_count == {COUNT_BITS{1'b1}}) ? match_count
                                                           : match_count + 1'b1;

    always_comb
    begin
        rank_new = rd_rank;
        if (pos_reg == target_reg)
        begin
            rank_new = '0;
        end
        else
        begin
            case (mode_reg)
                UPD_TOUCH:
                begin
                    if (rd_rank < match_rank)
                    begin
                        rank_new = rd_rank + 1'b1;
                    end
                end
                UPD_EVICT:
                begin
                    if (rd_rank <= victim_rank)
                    begin
                        rank_new = rd_rank + 1'b1;
                    end
                end
                UPD_INSERT:
                begin
                    rank_new = rd_rank + 1'b1;
                end
                default:
                begin
                    rank_new = rd_rank;
                end
            endcase
        end
    end

    always_comb
    begin
        slot_wr.rank_we  = (state_reg == ST_UPDATE) && chk_reg &&
                           ((pos_reg == target_reg) ||
                            (valid_reg[pos_reg] &&
                             !((mode_reg == UPD_EVICT) && (pos_reg == victim_idx))));
        slot_wr.tag_we   = (state_reg == ST_FINISH) && fin_go &&
                           ((mode_reg == UPD_EVICT) || (mode_reg == UPD_INSERT));
        slot_wr.count_we = (state_reg == ST_FINISH) && fin_go && (mode_reg != UPD_NONE);
        slot_wr.value_we = (state_reg == ST_FINISH) && fin_go && (mode_reg != UPD_NONE) &&
                           ((mode_reg != UPD_TOUCH) || (cmd_reg == CMD_PUT));
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        chk_next       = 1'b0;
        mode_next      = mode_reg;
        target_next    = target_reg;
        ign_next       = ign_reg;
        valid_next     = valid_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (walking && !walk_done)
        begin
            cnt_next = cnt_reg + 1'b1;
            chk_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (walk_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                mode_next = UPD_NONE;
                ign_next  = 1'b0;
                if (cmd_reg == CMD_GET)
                begin
                    if (match_found)
                    begin
                        mode_next   = UPD_TOUCH;
                        target_next = match_idx;
                    end
                end
                else if (cap_eff == '0)
                begin
                    ign_next = 1'b1;
                end
                else if (match_found)
                begin
                    mode_next   = UPD_TOUCH;
                    target_next = match_idx;
                end
                else if ((CAPW'(occ_reg) >= cap_eff) && victim_found)
                begin
                    mode_next   = UPD_EVICT;
                    target_next = (free_found && (free_idx < victim_idx)) ? free_idx
                                                                          : victim_idx;
                end
                else if (free_found)
                begin
                    mode_next   = UPD_INSERT;
                    target_next = free_idx;
                end
                cnt_next   = '0;
                state_next = (mode_next == UPD_NONE) ? ST_FINISH : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (mode_reg == UPD_EVICT)
                    begin
                        valid_next[victim_idx] = 1'b0;
                    end
                    if ((mode_reg == UPD_EVICT) || (mode_reg == UPD_INSERT))
                    begin
                        valid_next[target_reg] = 1'b1;
                    end
                    if (mode_reg == UPD_INSERT)
                    begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            chk_reg       <= 1'b0;
            mode_reg      <= UPD_NONE;
            ign_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            chk_reg       <= chk_next;
            mode_reg      <= mode_next;
            ign_reg       <= ign_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= cnt_reg[IW-1:0];
        target_reg <= target_next;
        if (in_accept)
        begin
            cmd_reg <= cmd;
            key_reg <= key_tag;
            val_reg <= put_value;
        end
        if ((state_reg == ST_FINISH) && fin_go)
        begin
            hit_reg         <= match_found;
            read_value_reg  <= ((cmd_reg == CMD_GET) && match_found) ? match_value : '0;
            evicted_reg     <= (mode_reg == UPD_EVICT);
            evicted_tag_reg <= (mode_reg == UPD_EVICT) ? victim_tag_out : '0;
            ignored_reg     <= ign_reg;
        end
    end

    lfu_slot_mem #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TAG_BITS    (TAG_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_slot_mem (
        .clk         (clk),
        .rd_addr     (cnt_reg[IW-1:0]),
        .wr          (slot_wr),
        .entry_waddr (target_reg),
        .wr_tag      (key_masked),
        .wr_value    (val_reg),
        .wr_count    ((mode_reg == UPD_TOUCH) ? count_new : COUNT_BITS'(1)),
        .rank_waddr  (pos_reg),
        .wr_rank     (rank_new),
        .rd_tag      (rd_tag),
        .rd_value    (rd_value),
        .rd_count    (rd_count),
        .rd_rank     (rd_rank)
    );

    lfu_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TAG_BITS    (TAG_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (scan_ctrl),
        .pos          (pos_reg),
        .entry_valid  (valid_reg[pos_reg]),
        .key          (key_masked),
        .rd_tag       (rd_tag),
        .rd_value     (rd_value),
        .rd_count     (rd_count),
        .rd_rank      (rd_rank),
        .match_found  (match_found),
        .match_idx    (match_idx),
        .match_value  (match_value),
        .match_count  (match_count),
        .match_rank   (match_rank),
        .free_found   (free_found),
        .free_idx     (free_idx),
        .victim_found (victim_found),
        .victim_idx   (victim_idx),
        .victim_tag   (victim_tag),
        .victim_rank  (victim_rank)
    );

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_tag = evicted_tag_reg;
    assign ignored     = ignored_reg;

    `LFU_ASSERT_NOW(a_occ_matches_valid, 1'b1, ($countones(valid_reg) == occ_reg), "occupancy count disagrees with valid slots")
    `LFU_ASSERT_NEXT(a_finish_loads_output, ((state_reg == ST_FINISH) && fin_go), (out_valid_reg && (state_reg == ST_IDLE)), "finished item did not reach the output register")
    `LFU_ASSERT_NOW(a_evict_has_victim, ((state_reg == ST_UPDATE) && (mode_reg == UPD_EVICT)), (victim_found && valid_reg[victim_idx]), "eviction without a valid victim")

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Sends gets and puts through the input channel and keeps a cycle-free model
// of the table: tags, values, use counts and recency order. Each result item
// is compared field by field with the model's answer. Directed items cover
// hits, misses, updates, eviction by count and by age, a zero capacity and a
// capacity above the table size. Random items then run over several
// capacities and idling phases, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import lfu_pkg::*;

    localparam int MAX_LINES = 16;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_tag;
        logic                  ignored;
    } cache_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_BITS-1:0]   capacity_in_use = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cmd = CMD_GET;
    logic [KEY_BITS-1:0]   key_tag = '0;
    logic [VALUE_BITS-1:0] put_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_tag;
    logic                  ignored;

    bit                    line_valid [MAX_LINES];
    bit [KEY_BITS-1:0]     line_tag   [MAX_LINES];
    bit [VALUE_BITS-1:0]   line_value [MAX_LINES];
    bit [15:0]             line_uses  [MAX_LINES];
    int unsigned           line_age   [MAX_LINES];
    int unsigned           lines_used = 0;
    bit [CAP_BITS-1:0]     cap_reg = 5'd10;

    cache_result_t         pending_results[$];
    bit [KEY_BITS-1:0]     key_pool[32];
    int                    errors = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_request = 0;
    int                    hold_left = 0;

    lfu_cache_table u_top (.*);

    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void bump_line(int s);
        if (line_uses[s] != 16'hFFFF)
            line_uses[s]++;
        for (int i = 0; i < MAX_LINES; i++)
            if (line_valid[i] && i != s && line_age[i] < line_age[s])
                line_age[i]++;
        line_age[s] = 0;
    endfunction

    function automatic cache_result_t predict_access(logic op, logic [KEY_BITS-1:0] key,
                                                     logic [VALUE_BITS-1:0] data);
        cache_result_t r;
        int            found;
        int            victim;
        int            slot;
        int unsigned   limit;
        int unsigned   old_age;
        r = '0;
        found = -1;
        victim = -1;
        slot = -1;
        limit = (cap_reg > MAX_LINES) ? MAX_LINES : cap_reg;
        for (int i = 0; i < MAX_LINES; i++)
            if (found < 0 && line_valid[i] && line_tag[i] == key)
                found = i;
        r.hit = (found >= 0);
        if (op == CMD_GET)
        begin
            if (found >= 0)
            begin
                r.read_value = line_value[found];
                bump_line(found);
            end
            return r;
        end
        if (limit == 0)
        begin
            r.ignored = 1'b1;
            return r;
        end
        if (found >= 0)
        begin
            line_value[found] = data;
            bump_line(found);
            return r;
        end
        if (lines_used >= limit)
        begin
            for (int i = 0; i < MAX_LINES; i++)
                if (line_valid[i] && (victim < 0 || line_uses[i] < line_uses[victim] ||
                    (line_uses[i] == line_uses[victim] && line_age[i] > line_age[victim])))
                    victim = i;
            if (victim >= 0)
            begin
                r.evicted = 1'b1;
                r.evicted_tag = line_tag[victim];
                old_age = line_age[victim];
                line_valid[victim] = 1'b0;
                for (int i = 0; i < MAX_LINES; i++)
                    if (line_valid[i] && line_age[i] > old_age)
                        line_age[i]--;
                if (lines_used > 0)
                    lines_used--;
            end
        end
        for (int i = 0; i < MAX_LINES; i++)
            if (slot < 0 && !line_valid[i])
                slot = i;
        if (slot < 0)
            return r;
        for (int i = 0; i < MAX_LINES; i++)
            if (line_valid[i])
                line_age[i]++;
        line_valid[slot] = 1'b1;
        line_tag[slot] = key;
        line_value[slot] = data;
        line_uses[slot] = 16'd1;
        line_age[slot] = 0;
        lines_used++;
        return r;
    endfunction

    task automatic send_op(logic op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] data);
        bit took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        key_tag <= key;
        put_value <= data;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        pending_results.insert(pending_results.size(), predict_access(op, key, data));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        bit rdy;
        wait_idle();
        cfg_valid <= 1'b1;
        capacity_in_use <= cap;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg_valid <= 1'b0;
        cap_reg = cap;
        @(posedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        wait_idle();
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    initial
    begin
        cache_result_t exp_r;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result item, hit %b value %h", $time, hit,
                             read_value);
                end
                else
                begin
                    exp_r = pending_results[0];
                    pending_results.delete(0);
                    check_field("hit", 32'(exp_r.hit), 32'(hit));
                    check_field("read_value", exp_r.read_value, read_value);
                    check_field("evicted", 32'(exp_r.evicted), 32'(evicted));
                    check_field("evicted_tag", exp_r.evicted_tag, evicted_tag);
                    check_field("ignored", 32'(exp_r.ignored), 32'(ignored));
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_op(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_op(CMD_GET, 32'hFFFF_FFFF, 32'h5555_5555);
        send_op(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_op(CMD_GET, 32'h0000_0000, 32'hAAAA_AAAA);
    endtask

    task automatic test_lfu_eviction();
        write_capacity(5'd16);
        send_op(CMD_PUT, 32'hA5A5_A5A5, 32'h0000_0001);
        send_op(CMD_PUT, 32'h5A5A_5A5A, 32'h0000_0002);
        send_op(CMD_PUT, 32'h0F0F_F0F0, 32'h0000_0003);
        write_capacity(5'd3);
        send_op(CMD_PUT, 32'h8000_0001, 32'h0000_0004);
        send_op(CMD_GET, 32'hA5A5_A5A5, 32'h0000_0000);
        send_op(CMD_PUT, 32'h7FFF_FFFE, 32'h0000_0005);
    endtask

    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_op(CMD_PUT, 32'h0000_0000, 32'hDEAD_BEEF);
        send_op(CMD_PUT, 32'h1357_9BDF, 32'hCAFE_F00D);
        send_op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_capacity_limit();
        write_capacity(5'd31);
        send_op(CMD_PUT, 32'h0000_1111, 32'h1111_0000);
        send_op(CMD_PUT, 32'h0000_2222, 32'h2222_0000);
        send_op(CMD_GET, 32'h0000_1111, 32'h0000_0000);
    endtask

    task automatic test_back_pressure();
        set_idling(0, 0);
        @(negedge clk);
        hold_request = 300;
        @(posedge clk);
        for (int i = 0; i < 6; i++)
            send_op(1'($urandom_range(1)), key_pool[i], $urandom);
    endtask

    task automatic test_random_traffic();
        bit [CAP_BITS-1:0] caps[8];
        int                pool_size;
        caps = '{5'd10, 5'd1, 5'd16, 5'd31, 5'd5, 5'd0, 5'd3, 5'd2};
        caps[7] = CAP_BITS'($urandom_range(1, 31));
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(82, 0);
                2: set_idling(0, 82);
                default: set_idling(9, 9);
            endcase
            write_capacity(caps[phase]);
            for (int k = 0; k < 32; k++)
                key_pool[k] = $urandom;
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hFFFF_FFFF;
            pool_size = $urandom_range(4, 28);
            for (int n = 0; n < 170; n++)
            begin
                if ($urandom_range(99) < 85)
                    send_op(1'($urandom_range(1)), key_pool[$urandom_range(pool_size - 1)],
                            $urandom);
                else
                    send_op(1'($urandom_range(1)), $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_lfu_eviction();
        test_capacity_zero();
        test_capacity_limit();
        test_back_pressure();
        test_random_traffic();
        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_slot_mem.sv
sv/lfu_scan.sv
sv/lfu_cache_table.sv
dv/tb.sv
